// ===== design/slht_pkg.sv =====
// ----------------------------------------------------------------------------
// slht_pkg: shared types and constants for the slew limited heading tracker
// Field widths, register indexes, controller states, the command and status
// groups between controller and datapath, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package slht_pkg;

  localparam int COORD_W   = 16;
  localparam int TICKS_W   = 20;
  localparam int RATE_W    = 16;
  localparam int HEAD_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Offsets are scaled by 256 before rotation; 28 bits hold the CORDIC growth.
  localparam int XY_W      = 28;
  localparam int PRESCALE  = 8;

  // The allowed step is the product shifted down by 16 bits.
  localparam int LIMIT_W   = RATE_W + TICKS_W - 16;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [CFG_DAT_W-1:0] CENTER_X_RST = 16'd400;
  localparam logic [CFG_DAT_W-1:0] CENTER_Y_RST = 16'd300;
  localparam logic [CFG_DAT_W-1:0] MAX_RATE_RST = 16'd2731;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_MAX_RATE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ROT,
    S_ERR,
    S_UPD
  } state_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic rotate;
    logic calc_err;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_sts_t;

  // atan(2^-i) as a fraction of a turn, rounded to ab bits per turn.
  function automatic logic [31:0] atan_angle(input int idx, input int ab);
    logic [31:0] raw;
    logic [32:0] sum;
    unique case (idx)
      0:       raw = 32'h20000000;
      1:       raw = 32'h12E4051E;
      2:       raw = 32'h09FB385B;
      3:       raw = 32'h051111D4;
      4:       raw = 32'h028B0D43;
      5:       raw = 32'h0145D7E1;
      6:       raw = 32'h00A2F61E;
      7:       raw = 32'h00517C55;
      8:       raw = 32'h0028BE53;
      9:       raw = 32'h00145F2F;
      10:      raw = 32'h000A2F98;
      11:      raw = 32'h000517CC;
      12:      raw = 32'h00028BE6;
      13:      raw = 32'h000145F3;
      14:      raw = 32'h0000A2F9;
      15:      raw = 32'h0000517C;
      16:      raw = 32'h000028BE;
      17:      raw = 32'h0000145F;
      18:      raw = 32'h00000A2F;
      19:      raw = 32'h00000517;
      20:      raw = 32'h0000028B;
      21:      raw = 32'h00000145;
      22:      raw = 32'h000000A2;
      23:      raw = 32'h00000051;
      default: raw = 32'h00000000;
    endcase
    sum = {1'b0, raw} + (33'd1 << (31 - ab));
    return 32'(sum >> (32 - ab));
  endfunction

endpackage

// ===== design/slht_if.sv =====
// ----------------------------------------------------------------------------
// slht_if: valid/ready channels of the heading tracker
// Target channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface slht_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [slht_pkg::COORD_W-1:0]        target_x;
  logic signed [slht_pkg::COORD_W-1:0]        target_y;
  logic        [slht_pkg::TICKS_W-1:0]        elapsed_ticks;

  modport source (output valid, target_x, target_y, elapsed_ticks, input ready);
  modport sink   (input valid, target_x, target_y, elapsed_ticks, output ready);
  modport mon    (input valid, ready, target_x, target_y, elapsed_ticks);
endinterface

interface slht_out_if;
  logic                                       valid;
  logic                                       ready;
  logic        [slht_pkg::HEAD_W-1:0]         heading;
  logic signed [slht_pkg::HEAD_W-1:0]         angle_error;
  logic                                       rate_limited;

  modport source (output valid, heading, angle_error, rate_limited, input ready);
  modport sink   (input valid, heading, angle_error, rate_limited, output ready);
  modport mon    (input valid, ready, heading, angle_error, rate_limited);
endinterface

interface slht_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [slht_pkg::CFG_IDX_W-1:0]             reg_index;
  logic [slht_pkg::CFG_DAT_W-1:0]             wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
  modport mon    (input valid, ready, reg_index, wdata);
endinterface

// ===== design/slew_limited_heading_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// slew_limited_heading_tracker_unit: rate limited heading follower
// Turns a stored heading toward the bearing of a target seen from a
// configured center, never faster than max_rate allows in the elapsed time.
// ----------------------------------------------------------------------------
//
//   channel  direction  carries                                   beat when
//   in_ch    sink       target_x, target_y, elapsed_ticks         valid & ready
//   out_ch   source     heading, angle_error, rate_limited        valid & ready
//   cfg_ch   sink       reg_index (0 center_x, 1 center_y,        valid & ready
//                       2 max_rate), wdata
//
// One target beat runs from acceptance through setup, the CORDIC rotations,
// the error step and the update step to a valid result; the rotations use the
// single shared CORDIC rotation stage that runs one iteration per cycle.
// Beats are worked one at a time; the next target is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// A stall on out_ch holds the finished beat in the update step until the
// output register frees up. Reset (rst_n low, synchronous) restores the
// register defaults and clears the heading to zero; no beat is taken on any
// channel while it is held.
// The configuration port accepts whenever reset is released; writes are meant
// for idle periods.
//
module slew_limited_heading_tracker_unit #(
  parameter int ANGLE_BITS   = slht_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = slht_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slht_in_if.sink    in_ch,
  slht_out_if.source out_ch,
  slht_cfg_if.sink   cfg_ch
);

  slht_pkg::dp_cmd_t cmd;
  slht_pkg::dp_sts_t sts;

  // Register writes only wait for reset to be released.
  assign cfg_ch.ready = rst_n;

  // The controller sequences the beat and owns both handshakes.
  slht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the registers, the CORDIC and the clamp.
  slht_dp #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_index     (cfg_ch.reg_index),
    .cfg_wdata     (cfg_ch.wdata),
    .target_x      (in_ch.target_x),
    .target_y      (in_ch.target_y),
    .elapsed_ticks (in_ch.elapsed_ticks),
    .heading       (out_ch.heading),
    .angle_error   (out_ch.angle_error),
    .rate_limited  (out_ch.rate_limited)
  );

endmodule

// ===== design/slht_ctrl.sv =====
// ----------------------------------------------------------------------------
// slht_ctrl: sequencer of the heading tracker
// Walks one beat through setup, CORDIC rotations, error and update, and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module slht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output slht_pkg::dp_cmd_t cmd,
  input  slht_pkg::dp_sts_t sts
);

  slht_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slht_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      slht_pkg::S_IDLE: begin
        // No target is taken while reset is held.
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_nxt   = slht_pkg::S_PREP;
        end
      end
      slht_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = slht_pkg::S_ROT;
      end
      slht_pkg::S_ROT: begin
        cmd.rotate = 1'b1;
        if (sts.last_step) begin
          state_nxt = slht_pkg::S_ERR;
        end
      end
      slht_pkg::S_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = slht_pkg::S_UPD;
      end
      slht_pkg::S_UPD: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = slht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = slht_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/slht_dp.sv =====
// ----------------------------------------------------------------------------
// slht_dp: datapath of the heading tracker
// Configuration registers, vectoring CORDIC with one shared rotation stage,
// rate limit multiply, heading register and result payload register.
// ----------------------------------------------------------------------------
module slht_dp #(
  parameter int ANGLE_BITS   = slht_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = slht_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  slht_pkg::dp_cmd_t                      cmd,
  output slht_pkg::dp_sts_t                      sts,
  input  logic                                   cfg_we,
  input  logic        [slht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [slht_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic signed [slht_pkg::COORD_W-1:0]    target_x,
  input  logic signed [slht_pkg::COORD_W-1:0]    target_y,
  input  logic        [slht_pkg::TICKS_W-1:0]    elapsed_ticks,
  output logic        [slht_pkg::HEAD_W-1:0]     heading,
  output logic signed [slht_pkg::HEAD_W-1:0]     angle_error,
  output logic                                   rate_limited
);

  localparam int CW  = slht_pkg::COORD_W;
  localparam int XW  = slht_pkg::XY_W;
  localparam int HW  = slht_pkg::HEAD_W;
  localparam int LW  = slht_pkg::LIMIT_W;
  localparam int SW  = $clog2(CORDIC_STEPS);
  localparam int PW  = slht_pkg::RATE_W + slht_pkg::TICKS_W;

  // Configuration registers.
  logic signed [CW-1:0]                 cx_r, cy_r;
  logic        [slht_pkg::RATE_W-1:0]   rate_r;

  // Captured beat.
  logic signed [CW-1:0]                 tx_r, ty_r;
  logic        [slht_pkg::TICKS_W-1:0]  ticks_r;

  // CORDIC state.
  logic signed [XW-1:0]                 x_r, y_r;
  logic        [ANGLE_BITS-1:0]         z_r;
  logic        [SW-1:0]                 step_r;
  logic                                 zero_r;

  logic        [LW-1:0]                 limit_r;
  logic signed [HW-1:0]                 err_r;
  logic        [HW-1:0]                 heading_r;

  logic        [HW-1:0]                 out_heading_r;
  logic signed [HW-1:0]                 out_err_r;
  logic                                 out_lim_r;

  // Setup: offsets, prescale and fold into the right half plane.
  logic signed [CW:0]                   dx, dy;
  logic signed [XW-1:0]                 x0, y0;
  logic [PW-1:0]                        product;

  always_comb begin
    dx = {tx_r[CW-1], tx_r} - {cx_r[CW-1], cx_r};
    dy = {ty_r[CW-1], ty_r} - {cy_r[CW-1], cy_r};
    x0 = {{(XW-CW-1-slht_pkg::PRESCALE){dx[CW]}}, dx, {slht_pkg::PRESCALE{1'b0}}};
    y0 = {{(XW-CW-1-slht_pkg::PRESCALE){dy[CW]}}, dy, {slht_pkg::PRESCALE{1'b0}}};
    product = PW'(rate_r) * PW'(ticks_r);
  end

  // One rotation per cycle, shift and arctangent picked by the step count.
  logic signed [XW-1:0]                 xs, ys;
  logic        [ANGLE_BITS-1:0]         atan_z;

  always_comb begin
    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
    atan_z = ANGLE_BITS'(slht_pkg::atan_angle(int'(step_r), ANGLE_BITS));
  end

  assign sts.last_step = (step_r == SW'(CORDIC_STEPS - 1));

  // Bring the angle accumulator to 16 bits per turn.
  logic [HW-1:0] z16;

  generate
    if (ANGLE_BITS > HW) begin : g_round
      logic [ANGLE_BITS:0] z_sum;
      assign z_sum = {1'b0, z_r} + ((ANGLE_BITS+1)'(1) << (ANGLE_BITS - HW - 1));
      assign z16   = z_sum[ANGLE_BITS-1 -: HW];
    end else if (ANGLE_BITS == HW) begin : g_same
      assign z16 = z_r;
    end else begin : g_widen
      assign z16 = {z_r, {(HW-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  logic [HW-1:0] bearing;
  assign bearing = zero_r ? '0 : z16;

  // Clamp of the error against the allowed step.
  logic signed [LW:0]   err_ext, lim_ext;
  logic                 over_pos, over_neg;
  logic [HW-1:0]        step_val;

  always_comb begin
    err_ext  = (LW+1)'(err_r);
    lim_ext  = {1'b0, limit_r};
    over_pos = err_ext > lim_ext;
    over_neg = err_ext < -lim_ext;
    if (over_pos) begin
      step_val = limit_r[HW-1:0];
    end else if (over_neg) begin
      step_val = -limit_r[HW-1:0];
    end else begin
      step_val = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= slht_pkg::CENTER_X_RST;
      cy_r      <= slht_pkg::CENTER_Y_RST;
      rate_r    <= slht_pkg::MAX_RATE_RST;
      heading_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          slht_pkg::REG_CENTER_X: cx_r   <= cfg_wdata;
          slht_pkg::REG_CENTER_Y: cy_r   <= cfg_wdata;
          slht_pkg::REG_MAX_RATE: rate_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.update) begin
        heading_r <= heading_r + step_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tx_r    <= target_x;
      ty_r    <= target_y;
      ticks_r <= elapsed_ticks;
    end
    if (cmd.prep) begin
      zero_r  <= (dx == '0) && (dy == '0);
      limit_r <= product[PW-1 -: LW];
      step_r  <= '0;
      if (dx[CW]) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end
    if (cmd.rotate) begin
      step_r <= step_r + SW'(1);
      if (!y_r[XW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_z;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_z;
      end
    end
    if (cmd.calc_err) begin
      err_r <= bearing - heading_r;
    end
    if (cmd.update) begin
      out_heading_r <= heading_r + step_val;
      out_err_r     <= err_r;
      out_lim_r     <= over_pos || over_neg;
    end
  end

  assign heading      = out_heading_r;
  assign angle_error  = out_err_r;
  assign rate_limited = out_lim_r;

endmodule

// ===== design/slht_checker.sv =====
// ----------------------------------------------------------------------------
// slht_checker: port level checks of the heading tracker
// Watches the three channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module slht_checker (
  input logic        clk,
  input logic        rst_n,
  slht_in_if.sink    in_ch,
  slht_out_if.source out_ch,
  slht_cfg_if.sink   cfg_ch
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result beat withdrawn while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A target beat is worked alone: no second beat on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second target accepted while one is in work");

  // The rate limit can only cut a step when there is an error to follow.
  a_limit_needs_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rate_limited |-> out_ch.angle_error != '0)
    else $error("rate limit flagged with zero angle error");

  // Register writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid |-> cfg_ch.ready)
    else $error("register write stalled");

endmodule

bind slew_limited_heading_tracker_unit slht_checker u_slht_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);
